### hw/rtl/subqflc_pkg.sv
`default_nettype none

package subqflc_pkg;

  typedef struct packed {
    logic [31:0] frame_word_a;
    logic [31:0] frame_word_b;
    logic [31:0] frame_word_c;
  } in_t;

  typedef struct packed {
    logic [5:0] lock_count;
    logic       inject_request;
    logic [1:0] frame_status;
  } out_t;

  typedef struct packed {
    logic [5:0] lock_trigger;
    logic [3:0] reload_gap;
    logic       vcd_exclusion;
  } cfg_t;

  // frame_status codes
  localparam logic [1:0] STATUS_EMPTY    = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_FILTERED = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_LOCK_TRIGGER  = 2'd0;
  localparam logic [1:0] REG_RELOAD_GAP    = 2'd1;
  localparam logic [1:0] REG_VCD_EXCLUSION = 2'd2;

  localparam logic [5:0] LOCK_TRIGGER_RST = 6'd20;
  localparam logic [3:0] RELOAD_GAP_RST   = 4'd6;

  localparam logic [5:0] COUNT_MAX     = 6'd63;
  localparam logic [3:0] ADR_MODE1     = 4'h1;
  localparam logic [7:0] CTRL_ADR_ONE  = 8'h01;
  localparam logic [7:0] TRACK_LIMIT   = 8'd100;
  localparam logic [7:0] INDEX_TOC_MIN = 8'hA0;
  localparam logic [7:0] INDEX_ONE     = 8'h01;
  localparam logic [7:0] TOP_VCD       = 8'h02;
  localparam logic [7:0] WRAP_OFFSET   = 8'h03;
  localparam logic [7:0] WRAP_MIN      = 8'hF5;

endpackage

`default_nettype wire

### hw/rtl/subqflc_step.sv
`default_nettype none

module subqflc_step (
  input  var subqflc_pkg::in_t  frame,
  input  var logic [5:0]        count,
  input  var subqflc_pkg::cfg_t cfg,
  output subqflc_pkg::out_t     result
);

  logic [31:0] a;
  logic [31:0] b;
  logic        empty;
  logic        reject;
  logic        data;
  logic [7:0]  idx;
  logic [7:0]  top;
  logic [7:0]  top_wrap;
  logic        masks_on;
  logic        inc_toc;
  logic        inc_wrap;
  logic        inc_hold;
  logic [5:0]  cnt_bump;
  logic [5:0]  cnt_filt;
  logic [5:0]  cnt_step;
  logic [1:0]  status;
  logic        inject;
  logic [5:0]  reload;

  assign a        = frame.frame_word_a;
  assign b        = frame.frame_word_b;
  assign empty    = ((a | b | frame.frame_word_c) == 32'd0);
  assign reject   = (a[3:0] != subqflc_pkg::ADR_MODE1) ||
                    (a[15:8] >= subqflc_pkg::TRACK_LIMIT);

  // data/TOC mask: bit 7 clear, bit 6 set, bit 4 clear
  assign data     = !a[7] && a[6] && !a[4];
  assign idx      = a[23:16];
  assign top      = a[31:24];
  assign top_wrap = top - subqflc_pkg::WRAP_OFFSET;
  assign masks_on = (a[15:8] == 8'd0) && (b[23:16] == 8'd0);

  assign inc_toc  = data && (idx >= subqflc_pkg::INDEX_TOC_MIN) &&
                    !(cfg.vcd_exclusion && (top == subqflc_pkg::TOP_VCD));
  assign inc_wrap = data && (idx == subqflc_pkg::INDEX_ONE) &&
                    (top_wrap >= subqflc_pkg::WRAP_MIN);
  assign inc_hold = (count != 6'd0) &&
                    ((a[7:0] == subqflc_pkg::CTRL_ADR_ONE) || data);

  assign cnt_bump = (count < subqflc_pkg::COUNT_MAX) ? count + 6'd1 : subqflc_pkg::COUNT_MAX;

  always_comb begin
    if (masks_on && (inc_toc || inc_wrap || inc_hold)) begin
      cnt_filt = cnt_bump;
    end else if (count != 6'd0) begin
      cnt_filt = count - 6'd1;
    end else begin
      cnt_filt = 6'd0;
    end
  end

  always_comb begin
    if (empty) begin
      cnt_step = count;
      status   = subqflc_pkg::STATUS_EMPTY;
    end else if (reject) begin
      cnt_step = count;
      status   = subqflc_pkg::STATUS_REJECTED;
    end else begin
      cnt_step = cnt_filt;
      status   = subqflc_pkg::STATUS_FILTERED;
    end
  end

  // trigger test runs on every frame, whatever its status
  assign inject = (cnt_step != 6'd0) && (cnt_step >= cfg.lock_trigger);
  assign reload = (cfg.lock_trigger > {2'b00, cfg.reload_gap}) ?
                  cfg.lock_trigger - {2'b00, cfg.reload_gap} : 6'd0;

  assign result = {(inject ? reload : cnt_step), inject, status};

endmodule

`default_nettype wire

### hw/rtl/subq_frame_lock_counter.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   subqflc_pkg::in_t  (three frame words)
// out_      output     out_valid/out_stall subqflc_pkg::out_t (count, request, status)
// cfg_      input      cfg_valid/cfg_ready cfg_index (2 bits), cfg_data (6 bits)
//
// One frame per cycle sustained while out_stall is low; a frame passes the input
// register, then the counter step into the result register, before out_valid.
// The lock counter updates in the same cycle the frame moves into the result
// register, so back-to-back frames see each other's count.
// Synchronous active-low reset clears valids and the counter and loads the
// configuration defaults.
// A stalled output holds the result; the input stage then fills and stalls.

module subq_frame_lock_counter (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              in_valid,
  output logic                  in_stall,
  input  var subqflc_pkg::in_t  in_data,
  output logic                  out_valid,
  input  var logic              out_stall,
  output subqflc_pkg::out_t     out_data,
  input  var logic              cfg_valid,
  output logic                  cfg_ready,
  input  var logic [1:0]        cfg_index,
  input  var logic [5:0]        cfg_data
);

  subqflc_pkg::cfg_t cfg_r;
  subqflc_pkg::in_t  frame_r;
  logic              frame_vld_r;
  logic [5:0]        lock_counter_r;
  subqflc_pkg::out_t out_data_r;
  logic              out_vld_r;
  subqflc_pkg::out_t step_res;
  logic              out_adv;
  logic              frame_mv;
  logic              in_xfer;

  assign out_adv   = !out_vld_r || !out_stall;
  assign frame_mv  = frame_vld_r && out_adv;
  assign in_stall  = frame_vld_r && !out_adv;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  subqflc_step u_step (
    .frame  (frame_r),
    .count  (lock_counter_r),
    .cfg    (cfg_r),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_trigger  <= subqflc_pkg::LOCK_TRIGGER_RST;
      cfg_r.reload_gap    <= subqflc_pkg::RELOAD_GAP_RST;
      cfg_r.vcd_exclusion <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        subqflc_pkg::REG_LOCK_TRIGGER:  cfg_r.lock_trigger  <= cfg_data;
        subqflc_pkg::REG_RELOAD_GAP:    cfg_r.reload_gap    <= cfg_data[3:0];
        subqflc_pkg::REG_VCD_EXCLUSION: cfg_r.vcd_exclusion <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= 1'b0;
    end else if (in_xfer) begin
      frame_vld_r <= 1'b1;
    end else if (frame_mv) begin
      frame_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_counter_r <= 6'd0;
      out_vld_r      <= 1'b0;
    end else begin
      if (frame_mv) begin
        lock_counter_r <= step_res.lock_count;
      end
      if (out_adv) begin
        out_vld_r <= frame_mv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_mv) begin
      out_data_r <= step_res;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/subqflc_checker.sv
`default_nettype none

module subqflc_checker (
  input var logic              clk,
  input var logic              rst_n,
  input var logic              in_stall,
  input var logic              out_valid,
  input var logic              out_stall,
  input var subqflc_pkg::out_t out_data,
  input var logic              cfg_valid,
  input var logic              cfg_ready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the input side stalls only behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

  // the configuration port never backpressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write not taken");

endmodule

bind subq_frame_lock_counter subqflc_checker u_subqflc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

### test/subq_frame_lock_checker.sv
module subq_frame_lock_checker (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              in_valid,
  input  var logic              in_stall,
  input  var subqflc_pkg::in_t  in_data,
  input  var logic              out_valid,
  input  var logic              out_stall,
  input  var subqflc_pkg::out_t out_data,
  input  var logic              cfg_valid,
  input  var logic              cfg_ready,
  input  var logic [1:0]        cfg_index,
  input  var logic [5:0]        cfg_data,
  output int                    errors,
  output int                    outstanding
);

  // control/ADR byte pattern of a data-track frame
  localparam logic [7:0] DATA_MASK = 8'hD0;
  localparam logic [7:0] DATA_CTRL = 8'h40;

  subqflc_pkg::cfg_t settings;
  logic [5:0]        lock_cnt;
  subqflc_pkg::out_t results_due[$];

  function automatic logic [5:0] bump(logic [5:0] c);
    return (c == subqflc_pkg::COUNT_MAX) ? c : c + 6'd1;
  endfunction

  function automatic logic [5:0] filtered_count(subqflc_pkg::in_t f, logic [5:0] c,
                                                logic excl);
    logic       data_frame;
    logic [7:0] ctrl;
    logic [7:0] idx;
    logic [7:0] top;
    logic [7:0] wrap_sec;
    ctrl       = f.frame_word_a[7:0];
    idx        = f.frame_word_a[23:16];
    top        = f.frame_word_a[31:24];
    wrap_sec   = top - subqflc_pkg::WRAP_OFFSET;
    data_frame = (ctrl & DATA_MASK) == DATA_CTRL;
    if (f.frame_word_a[15:8] == 8'h00 && f.frame_word_b[23:16] == 8'h00) begin
      if (data_frame) begin
        if (idx >= subqflc_pkg::INDEX_TOC_MIN && !(excl && top == subqflc_pkg::TOP_VCD))
          return bump(c);
        if (idx == subqflc_pkg::INDEX_ONE && wrap_sec >= subqflc_pkg::WRAP_MIN)
          return bump(c);
      end
      if (c != 6'd0 && (ctrl == subqflc_pkg::CTRL_ADR_ONE || data_frame)) return bump(c);
    end
    return (c != 6'd0) ? c - 6'd1 : c;
  endfunction

  // advance the lock counter by one frame and build its result
  function automatic subqflc_pkg::out_t lock_step(subqflc_pkg::in_t f);
    subqflc_pkg::out_t r;
    r = '0;
    if (f == '0) begin
      r.frame_status = subqflc_pkg::STATUS_EMPTY;
    end else if (f.frame_word_a[3:0] != subqflc_pkg::ADR_MODE1 ||
                 f.frame_word_a[15:8] >= subqflc_pkg::TRACK_LIMIT) begin
      r.frame_status = subqflc_pkg::STATUS_REJECTED;
    end else begin
      r.frame_status = subqflc_pkg::STATUS_FILTERED;
      lock_cnt = filtered_count(f, lock_cnt, settings.vcd_exclusion);
    end
    // reload test runs on every frame, whatever its status
    if (lock_cnt != 6'd0 && lock_cnt >= settings.lock_trigger) begin
      r.inject_request = 1'b1;
      lock_cnt = (settings.lock_trigger > {2'b00, settings.reload_gap}) ?
                 settings.lock_trigger - {2'b00, settings.reload_gap} : 6'd0;
    end
    r.lock_count = lock_cnt;
    return r;
  endfunction

  task automatic report_field(string field, logic [5:0] expv, logic [5:0] actv);
    if (actv !== expv) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    subqflc_pkg::out_t want;
    if (!rst_n) begin
      settings.lock_trigger  = subqflc_pkg::LOCK_TRIGGER_RST;
      settings.reload_gap    = subqflc_pkg::RELOAD_GAP_RST;
      settings.vcd_exclusion = 1'b0;
      lock_cnt = '0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          subqflc_pkg::REG_LOCK_TRIGGER:  settings.lock_trigger  = cfg_data;
          subqflc_pkg::REG_RELOAD_GAP:    settings.reload_gap    = cfg_data[3:0];
          subqflc_pkg::REG_VCD_EXCLUSION: settings.vcd_exclusion = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, got %p", $time, out_data);
        end else begin
          want = results_due.pop_front();
          report_field("lock_count", want.lock_count, out_data.lock_count);
          report_field("inject_request", {5'd0, want.inject_request},
                       {5'd0, out_data.inject_request});
          report_field("frame_status", {4'd0, want.frame_status},
                       {4'd0, out_data.frame_status});
        end
      end
      if (in_valid && !in_stall) results_due.push_back(lock_step(in_data));
    end
    outstanding = results_due.size();
  end

endmodule

### test/tb_subq_frame_lock_counter.sv
module tb_subq_frame_lock_counter;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDLE_PCT       = 38;
  localparam int PHASES         = 8;
  localparam int PHASE_FRAMES   = 235;
  localparam int SET_PHASES     = 6;

  typedef enum {FR_EMPTY, FR_BAD_ADR, FR_BAD_TRACK, FR_TOC, FR_WRAP, FR_HOLD, FR_ANY} frame_kind_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  subqflc_pkg::in_t  in_data   = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  subqflc_pkg::out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = subqflc_pkg::REG_LOCK_TRIGGER;
  logic [5:0]        cfg_data  = '0;
  bit                no_idle   = 1'b0;
  int                errors;
  int                outstanding;
  int                quiet_cycles = 0;

  // trigger, gap and exclusion per fixed phase; later phases draw them at random
  logic [5:0] phase_trig [SET_PHASES] = '{6'd63, 6'd1, 6'd0, 6'd4, 6'd63, 6'd12};
  logic [5:0] phase_gap  [SET_PHASES] = '{6'd15, 6'd0, 6'd9, 6'd15, 6'd0, 6'd3};
  logic [5:0] phase_excl [SET_PHASES] = '{6'd1, 6'd0, 6'd1, 6'd0, 6'd0, 6'd1};

  // {word a, word b, word c}
  subqflc_pkg::in_t corner_frames [20] = '{
    {32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    {32'h0000_0000, 32'h0000_0000, 32'h0000_0001},
    {32'h0000_0000, 32'h8000_0000, 32'h0000_0000},
    {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {32'h0000_6301, 32'h0000_0000, 32'h0000_0000},
    {32'h0000_6401, 32'h0000_0000, 32'h0000_0000},
    {32'h0000_FF01, 32'h0000_0000, 32'h0000_0000},
    {32'h00A0_0041, 32'h0000_0000, 32'h0000_0000},
    {32'h02FF_0061, 32'hFF00_FFFF, 32'hFFFF_FFFF},
    {32'hF801_0041, 32'h0000_0000, 32'h0000_0000},
    {32'h0201_0041, 32'h0000_0000, 32'h0000_0000},
    {32'h0301_0041, 32'h0000_0000, 32'h0000_0000},
    {32'h1234_0001, 32'h0000_0000, 32'h0000_0000},
    {32'h00A0_0041, 32'h00FF_0000, 32'h0000_0000},
    {32'h00A0_0051, 32'h0000_0000, 32'h0000_0000},
    {32'h00A0_00C1, 32'h0000_0000, 32'h0000_0000},
    {32'h009F_0041, 32'h0000_0000, 32'h0000_0000},
    {32'hFFFF_00F1, 32'h0000_0000, 32'h0000_0000},
    {32'h0000_0000, 32'h0000_0000, 32'h8000_0000},
    {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  subq_frame_lock_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  subq_frame_lock_checker lock_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // end the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // data-track control/ADR byte with the free bit at random
  function automatic logic [7:0] data_ctrl();
    return {2'b01, 1'($urandom_range(0, 1)), 1'b0, subqflc_pkg::ADR_MODE1};
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return FR_EMPTY;
    if (r < 13) return FR_BAD_ADR;
    if (r < 20) return FR_BAD_TRACK;
    if (r < 45) return FR_TOC;
    if (r < 60) return FR_WRAP;
    if (r < 82) return FR_HOLD;
    return FR_ANY;
  endfunction

  function automatic subqflc_pkg::in_t make_frame(frame_kind_t kind);
    subqflc_pkg::in_t f;
    logic [7:0]       top;
    f.frame_word_a = $urandom();
    f.frame_word_b = $urandom();
    f.frame_word_c = $urandom();
    case (kind)
      FR_EMPTY: f = '0;
      FR_BAD_ADR: begin
        while (f.frame_word_a[3:0] == subqflc_pkg::ADR_MODE1)
          f.frame_word_a[3:0] = 4'($urandom());
      end
      FR_BAD_TRACK: begin
        f.frame_word_a[3:0]  = subqflc_pkg::ADR_MODE1;
        f.frame_word_a[15:8] = 8'($urandom_range(100, 255));
      end
      FR_TOC: begin
        top = ($urandom_range(0, 3) == 0) ? subqflc_pkg::TOP_VCD : 8'($urandom());
        f.frame_word_a = {top, 8'($urandom_range(8'hA0, 8'hFF)), 8'h00, data_ctrl()};
        f.frame_word_b[23:16] = 8'h00;
      end
      FR_WRAP: begin
        // mostly inside the early seconds window, which wraps past zero
        top = ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
              subqflc_pkg::WRAP_MIN + subqflc_pkg::WRAP_OFFSET + 8'($urandom_range(0, 10));
        f.frame_word_a = {top, subqflc_pkg::INDEX_ONE, 8'h00, data_ctrl()};
        f.frame_word_b[23:16] = 8'h00;
      end
      FR_HOLD: begin
        f.frame_word_a[15:0]  = {8'h00, ($urandom_range(0, 1) ? subqflc_pkg::CTRL_ADR_ONE :
                                         data_ctrl())};
        f.frame_word_b[23:16] = 8'h00;
      end
      default: begin
        f.frame_word_a[3:0]  = subqflc_pkg::ADR_MODE1;
        f.frame_word_a[15:8] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 99));
        if ($urandom_range(0, 1)) f.frame_word_b[23:16] = 8'h00;
      end
    endcase
    return f;
  endfunction

  // hold the frame until the transfer, then leave valid high for the caller
  task automatic send_frame(subqflc_pkg::in_t f);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(logic [5:0] trig, logic [5:0] gap, logic [5:0] excl);
    write_reg(subqflc_pkg::REG_LOCK_TRIGGER, trig);
    write_reg(subqflc_pkg::REG_RELOAD_GAP, gap);
    write_reg(subqflc_pkg::REG_VCD_EXCLUSION, excl);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner frames run on the reset settings
    foreach (corner_frames[i]) send_frame(corner_frames[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < SET_PHASES) configure(phase_trig[p], phase_gap[p], phase_excl[p]);
      else configure(6'($urandom()), 6'($urandom()), 6'($urandom()));
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_FRAMES; n++) send_frame(make_frame(pick_kind()));
    end

    drain();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
